// File: src/ffba_pkg.sv
// Package for the first-fit block allocator: request and response beat types,
// status codes, mode codes and default pool dimensions.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ffba_pkg;

    localparam int BLOCK_COUNT_DEF = 64;
    localparam int BLOCK_BYTES_DEF = 32;

    localparam int REQ_BYTES_W = 16;
    localparam int DIV_NUM_W   = 17;
    localparam int DIV_RECIP_W = 18;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
    localparam logic [2:0] ST_OVER_TOTAL = 3'd2;
    localparam logic [2:0] ST_OVER_FREE  = 3'd3;
    localparam logic [2:0] ST_NO_HANDLE  = 3'd4;
    localparam logic [2:0] ST_NO_RUN     = 3'd5;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd6;

    typedef struct packed {
        logic                   mode;
        logic [REQ_BYTES_W-1:0] request_bytes;
        logic [5:0]             handle;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  granted_handle;
        logic [5:0]  first_block;
        logic [10:0] byte_offset;
        logic [11:0] granted_bytes;
        logic [6:0]  blocks_in_use;
        logic [6:0]  peak_blocks;
        logic [31:0] request_total;
    } rsp_t;

endpackage

// File: src/first_fit_block_allocator.sv
// First-fit block allocator: top level with the block map and handle table memories.
// Depends on ffba_pkg for the beat types, status codes and default dimensions.
//
// The block serves one request at a time. After reset it clears its block map and
// handle table, stalling requests meanwhile. An allocate runs the size checks, then
// scans the handle table for a free handle and the block map for a first-fit run,
// both through the single read port of each memory, then marks the run's blocks,
// forms the result and returns to idle. A free reads the handle's entry, releases
// its blocks and returns the result. The response register lets a finished beat
// wait while the next request is accepted.
module first_fit_block_allocator #(
    parameter int BLOCK_COUNT = ffba_pkg::BLOCK_COUNT_DEF,
    parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ffba_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ffba_pkg::rsp_t  rsp
);

    localparam int IDX_W   = $clog2(BLOCK_COUNT);
    localparam int CNT_W   = $clog2(BLOCK_COUNT + 1);
    localparam int BB_W    = $clog2(BLOCK_BYTES + 1);
    localparam int HE_W    = 1 + IDX_W + CNT_W;
    localparam int DIV_L   = $clog2(BLOCK_BYTES);
    localparam int DIV_SH  = ffba_pkg::DIV_NUM_W + DIV_L;
    localparam int PROD_W  = ffba_pkg::DIV_NUM_W + ffba_pkg::DIV_RECIP_W;
    localparam longint unsigned DIV_M =
        ((64'd1 << DIV_SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    localparam logic [31:0] TOTAL_BYTES = 32'(BLOCK_COUNT * BLOCK_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_COUNT - 1);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd2;
    localparam logic [3:0] S_CHECK    = 4'd3;
    localparam logic [3:0] S_HSCAN    = 4'd4;
    localparam logic [3:0] S_BSCAN    = 4'd5;
    localparam logic [3:0] S_MARK     = 4'd6;
    localparam logic [3:0] S_FREE_RD  = 4'd7;
    localparam logic [3:0] S_FREE_CHK = 4'd8;
    localparam logic [3:0] S_UNMARK   = 4'd9;
    localparam logic [3:0] S_MUL      = 4'd10;
    localparam logic [3:0] S_RESP     = 4'd11;

    logic [3:0]                          state_reg, state_next;
    ffba_pkg::req_t                      req_reg;
    logic [2:0]                          status_reg;
    logic [ffba_pkg::DIV_NUM_W-1:0]      want_reg;
    logic [CNT_W-1:0]                    len_reg;
    logic [IDX_W-1:0]                    start_reg;
    logic [IDX_W-1:0]                    hnd_reg;
    logic [IDX_W-1:0]                    scan_reg;
    logic                                pend_reg;
    logic [IDX_W-1:0]                    pend_idx_reg;
    logic [CNT_W-1:0]                    run_reg;
    logic [IDX_W-1:0]                    run_start_reg;
    logic [IDX_W-1:0]                    addr_reg;
    logic [CNT_W-1:0]                    rem_reg;
    logic [CNT_W-1:0]                    used_reg;
    logic [CNT_W-1:0]                    live_reg;
    logic [CNT_W-1:0]                    peak_reg;
    logic [31:0]                         total_reg;
    logic [10:0]                         off_reg;
    logic [11:0]                         bytes_reg;
    logic                                rsp_valid_reg;
    ffba_pkg::rsp_t                      rsp_reg;

    logic                                map_mem [BLOCK_COUNT];
    logic [HE_W-1:0]                     hmem [BLOCK_COUNT];
    logic                                map_rdata;
    logic [HE_W-1:0]                     h_rdata;

    logic                                map_we;
    logic                                map_wdata;
    logic [IDX_W-1:0]                    map_raddr;
    logic                                h_we;
    logic [IDX_W-1:0]                    h_waddr;
    logic [HE_W-1:0]                     h_wdata;
    logic [IDX_W-1:0]                    h_raddr;

    logic                                accept;
    logic [ffba_pkg::DIV_NUM_W-1:0]      div_num;
    logic [PROD_W-1:0]                   div_prod;
    logic [2:0]                          chk_status;
    logic                                h_rvalid;
    logic [IDX_W-1:0]                    h_rstart;
    logic [CNT_W-1:0]                    h_rlen;
    logic                                h_found;
    logic [IDX_W-1:0]                    blk_start;
    logic [CNT_W-1:0]                    blk_run;
    logic                                blk_hit;
    logic                                blk_last;
    logic                                free_oor;
    logic [CNT_W-1:0]                    used_after;
    logic [IDX_W+BB_W-1:0]               off_prod;
    logic [CNT_W+BB_W-1:0]               len_prod;
    logic                                res_ok;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign div_num  = ffba_pkg::DIV_NUM_W'(req_reg.request_bytes)
                    + ffba_pkg::DIV_NUM_W'(BLOCK_BYTES - 1);
    assign div_prod = PROD_W'(div_num) * PROD_W'(DIV_M);

    always_comb
    begin
        priority if (req_reg.request_bytes == '0)
            chk_status = ffba_pkg::ST_ZERO_SIZE;
        else if (32'(req_reg.request_bytes) > TOTAL_BYTES)
            chk_status = ffba_pkg::ST_OVER_TOTAL;
        else if (want_reg > ffba_pkg::DIV_NUM_W'(CNT_W'(BLOCK_COUNT) - used_reg))
            chk_status = ffba_pkg::ST_OVER_FREE;
        else if (live_reg >= CNT_W'(BLOCK_COUNT))
            chk_status = ffba_pkg::ST_NO_HANDLE;
        else
            chk_status = ffba_pkg::ST_OK;
    end

    assign h_rvalid  = h_rdata[HE_W-1];
    assign h_rstart  = h_rdata[CNT_W +: IDX_W];
    assign h_rlen    = h_rdata[CNT_W-1:0];
    assign h_found   = pend_reg && !h_rvalid;

    assign blk_start = (run_reg == '0) ? pend_idx_reg : run_start_reg;
    assign blk_run   = run_reg + CNT_W'(1);
    assign blk_hit   = pend_reg && !map_rdata && (blk_run >= len_reg);
    assign blk_last  = pend_reg && (pend_idx_reg == LAST_IDX);

    assign free_oor   = (32'(req_reg.handle) >= 32'(BLOCK_COUNT));
    assign used_after = used_reg + len_reg;
    assign off_prod   = (IDX_W+BB_W)'(start_reg) * (IDX_W+BB_W)'(BLOCK_BYTES);
    assign len_prod   = (CNT_W+BB_W)'(len_reg) * (CNT_W+BB_W)'(BLOCK_BYTES);
    assign res_ok     = (status_reg == ffba_pkg::ST_OK);

    always_comb
    begin
        state_next = state_reg;
        map_we     = 1'b0;
        map_wdata  = 1'b0;
        map_raddr  = scan_reg;
        h_we       = 1'b0;
        h_waddr    = hnd_reg;
        h_wdata    = '0;
        h_raddr    = scan_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                map_we  = 1'b1;
                h_we    = 1'b1;
                h_waddr = addr_reg;
                if (addr_reg == LAST_IDX)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = (req.mode == ffba_pkg::MODE_ALLOC) ? S_DIV : S_FREE_RD;
            end
            S_DIV:
                state_next = S_CHECK;
            S_CHECK:
                state_next = (chk_status == ffba_pkg::ST_OK) ? S_HSCAN : S_MUL;
            S_HSCAN:
            begin
                if (h_found)
                    state_next = S_BSCAN;
            end
            S_BSCAN:
            begin
                if (blk_hit)
                begin
                    h_we       = 1'b1;
                    h_wdata    = {1'b1, blk_start, len_reg};
                    state_next = S_MARK;
                end
                else if (blk_last)
                    state_next = S_MUL;
            end
            S_MARK:
            begin
                map_we    = 1'b1;
                map_wdata = 1'b1;
                if (rem_reg == CNT_W'(1))
                    state_next = S_MUL;
            end
            S_FREE_RD:
            begin
                h_raddr    = IDX_W'(req_reg.handle);
                state_next = free_oor ? S_MUL : S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                if (h_rvalid)
                begin
                    h_we       = 1'b1;
                    h_wdata    = {1'b0, h_rstart, h_rlen};
                    state_next = S_UNMARK;
                end
                else
                    state_next = S_MUL;
            end
            S_UNMARK:
            begin
                map_we = 1'b1;
                if (rem_reg == CNT_W'(1))
                    state_next = S_MUL;
            end
            S_MUL:
                state_next = S_RESP;
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[addr_reg] <= map_wdata;
        map_rdata <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            hmem[h_waddr] <= h_wdata;
        h_rdata <= hmem[h_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            used_reg      <= '0;
            live_reg      <= '0;
            peak_reg      <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_next == state_reg)
                      && (state_reg == S_HSCAN || state_reg == S_BSCAN);
            if (state_reg == S_RESP && state_next == S_IDLE)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                    addr_reg <= (addr_reg == LAST_IDX) ? '0 : addr_reg + IDX_W'(1);
                S_IDLE:
                begin
                    if (accept && req.mode == ffba_pkg::MODE_ALLOC)
                        total_reg <= total_reg + 32'd1;
                end
                S_BSCAN:
                begin
                    if (blk_hit)
                    begin
                        addr_reg <= blk_start;
                        used_reg <= used_after;
                        live_reg <= live_reg + CNT_W'(1);
                        if (used_after > peak_reg)
                            peak_reg <= used_after;
                    end
                end
                S_MARK, S_UNMARK:
                    addr_reg <= addr_reg + IDX_W'(1);
                S_FREE_CHK:
                begin
                    if (h_rvalid)
                    begin
                        addr_reg <= h_rstart;
                        used_reg <= used_reg - h_rlen;
                        live_reg <= live_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= scan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    req_reg <= req;
            end
            S_DIV:
                want_reg <= ffba_pkg::DIV_NUM_W'(div_prod >> DIV_SH);
            S_CHECK:
            begin
                status_reg <= chk_status;
                len_reg    <= CNT_W'(want_reg);
                scan_reg   <= '0;
                run_reg    <= '0;
            end
            S_HSCAN:
            begin
                if (h_found)
                begin
                    hnd_reg  <= pend_idx_reg;
                    scan_reg <= '0;
                end
                else
                    scan_reg <= scan_reg + IDX_W'(1);
            end
            S_BSCAN:
            begin
                scan_reg <= scan_reg + IDX_W'(1);
                if (pend_reg)
                begin
                    if (map_rdata)
                        run_reg <= '0;
                    else
                    begin
                        run_reg       <= blk_run;
                        run_start_reg <= blk_start;
                    end
                end
                if (blk_hit)
                begin
                    start_reg <= blk_start;
                    rem_reg   <= len_reg;
                end
                else if (blk_last)
                    status_reg <= ffba_pkg::ST_NO_RUN;
            end
            S_MARK, S_UNMARK:
                rem_reg <= rem_reg - CNT_W'(1);
            S_FREE_RD:
            begin
                status_reg <= free_oor ? ffba_pkg::ST_BAD_HANDLE : ffba_pkg::ST_OK;
                hnd_reg    <= IDX_W'(req_reg.handle);
            end
            S_FREE_CHK:
            begin
                if (h_rvalid)
                begin
                    start_reg <= h_rstart;
                    len_reg   <= h_rlen;
                    rem_reg   <= h_rlen;
                end
                else
                    status_reg <= ffba_pkg::ST_BAD_HANDLE;
            end
            S_MUL:
            begin
                off_reg   <= 11'(off_prod);
                bytes_reg <= 12'(len_prod);
            end
            S_RESP:
            begin
                if (state_next == S_IDLE)
                begin
                    rsp_reg.status         <= status_reg;
                    rsp_reg.granted_handle <= !res_ok ? 6'd0
                        : (req_reg.mode == ffba_pkg::MODE_FREE) ? req_reg.handle
                        : 6'(hnd_reg);
                    rsp_reg.first_block    <= res_ok ? 6'(start_reg) : 6'd0;
                    rsp_reg.byte_offset    <= res_ok ? off_reg : 11'd0;
                    rsp_reg.granted_bytes  <= res_ok ? bytes_reg : 12'd0;
                    rsp_reg.blocks_in_use  <= 7'(used_reg);
                    rsp_reg.peak_blocks    <= 7'(peak_reg);
                    rsp_reg.request_total  <= total_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: src/ffba_checker.sv
// Port-level checker for the first-fit block allocator, with its bind statement.
// Depends on ffba_pkg for the response type and status codes.
module ffba_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input ffba_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("A stalled response beat changed or was withdrawn.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ffba_pkg::ST_OK |->
            rsp.granted_handle == '0 && rsp.first_block == '0
            && rsp.byte_offset == '0 && rsp.granted_bytes == '0)
        else $error("A failed request reported a grant.");

    a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ffba_pkg::ST_OK |-> rsp.granted_bytes != '0)
        else $error("A successful request reported an empty run.");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.peak_blocks >= rsp.blocks_in_use)
        else $error("The high-water mark fell below the blocks in use.");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// File: test/first_fit_block_allocator_tb.sv
// Self-checking testbench for first_fit_block_allocator: directed and random requests, with
// every response checked against an in-bench prediction of the pool state.
// Depends on ffba_pkg and the block's RTL in src.
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;

    localparam int BLOCK_COUNT    = ffba_pkg::BLOCK_COUNT_DEF;
    localparam int BLOCK_BYTES    = ffba_pkg::BLOCK_BYTES_DEF;
    localparam int POOL_BYTES     = BLOCK_COUNT * BLOCK_BYTES;
    localparam int DRAIN_CYCLES   = 3 * BLOCK_COUNT + 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int QUIET_ITEMS    = 300;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    ffba_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    ffba_pkg::rsp_t rsp;

    bit          pool_block_used [BLOCK_COUNT];
    bit          pool_handle_live[BLOCK_COUNT];
    int unsigned pool_handle_start[BLOCK_COUNT];
    int unsigned pool_handle_len [BLOCK_COUNT];
    int unsigned pool_used_blocks  = 0;
    int unsigned pool_live_handles = 0;
    int unsigned pool_peak_blocks  = 0;
    logic [31:0] pool_alloc_requests = '0;

    ffba_pkg::rsp_t pending_responses[$];
    ffba_pkg::rsp_t head_rsp;
    int          error_count   = 0;
    int          items_sent    = 0;
    int          status_seen[8];
    int          quiet_cycles  = 0;
    int          hold_left     = 0;
    bit          hold_requested = 1'b0;
    bit          no_idle       = 1'b0;

    first_fit_block_allocator #(
        .BLOCK_COUNT(BLOCK_COUNT),
        .BLOCK_BYTES(BLOCK_BYTES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always #10 clk = ~clk;

    function automatic ffba_pkg::rsp_t predict_response(input ffba_pkg::req_t r);
        ffba_pkg::rsp_t e;
        int unsigned size;
        int unsigned want;
        int unsigned h;
        int unsigned start;
        int unsigned run;
        int unsigned i;
        e = '0;
        e.status = ffba_pkg::ST_OK;
        start = 0;
        want = 0;
        if (r.mode == ffba_pkg::MODE_ALLOC)
        begin
            pool_alloc_requests = pool_alloc_requests + 32'd1;
            size = 32'(r.request_bytes);
            want = (size + BLOCK_BYTES - 1) / BLOCK_BYTES;
            h = BLOCK_COUNT;
            for (i = 0; i < BLOCK_COUNT; i++)
                if (!pool_handle_live[i] && h == BLOCK_COUNT)
                    h = i;
            run = 0;
            for (i = 0; i < BLOCK_COUNT && (run < want || want == 0); i++)
            begin
                if (pool_block_used[i])
                    run = 0;
                else
                begin
                    if (run == 0)
                        start = i;
                    run++;
                end
            end
            if (size == 0)
                e.status = ffba_pkg::ST_ZERO_SIZE;
            else if (size > POOL_BYTES)
                e.status = ffba_pkg::ST_OVER_TOTAL;
            else if (size > (BLOCK_COUNT - pool_used_blocks) * BLOCK_BYTES)
                e.status = ffba_pkg::ST_OVER_FREE;
            else if (pool_live_handles >= BLOCK_COUNT || h == BLOCK_COUNT)
                e.status = ffba_pkg::ST_NO_HANDLE;
            else if (run < want)
                e.status = ffba_pkg::ST_NO_RUN;
            else
            begin
                for (i = 0; i < want; i++)
                    pool_block_used[start + i] = 1'b1;
                pool_handle_live[h]  = 1'b1;
                pool_handle_start[h] = start;
                pool_handle_len[h]   = want;
                pool_live_handles++;
                pool_used_blocks += want;
                if (pool_used_blocks > pool_peak_blocks)
                    pool_peak_blocks = pool_used_blocks;
                e.granted_handle = 6'(h);
            end
        end
        else
        begin
            h = 32'(r.handle);
            if (h >= BLOCK_COUNT || !pool_handle_live[h])
                e.status = ffba_pkg::ST_BAD_HANDLE;
            else
            begin
                start = pool_handle_start[h];
                want  = pool_handle_len[h];
                for (i = 0; i < want; i++)
                begin
                    if (start + i < BLOCK_COUNT && pool_block_used[start + i])
                    begin
                        pool_block_used[start + i] = 1'b0;
                        if (pool_used_blocks > 0)
                            pool_used_blocks--;
                    end
                end
                pool_handle_live[h] = 1'b0;
                if (pool_live_handles > 0)
                    pool_live_handles--;
                e.granted_handle = 6'(h);
            end
        end
        if (e.status == ffba_pkg::ST_OK)
        begin
            e.first_block   = 6'(start);
            e.byte_offset   = 11'(start * BLOCK_BYTES);
            e.granted_bytes = 12'(want * BLOCK_BYTES);
        end
        e.blocks_in_use = 7'(pool_used_blocks);
        e.peak_blocks   = 7'(pool_peak_blocks);
        e.request_total = pool_alloc_requests;
        return e;
    endfunction

    function automatic int pick_live_handle();
        int live_list[$];
        for (int i = 0; i < BLOCK_COUNT; i++)
            if (pool_handle_live[i])
                live_list.push_back(i);
        if (live_list.size() == 0)
            return -1;
        return live_list[$urandom_range(live_list.size() - 1)];
    endfunction

    function automatic void compare_field(input string field_name, input logic [31:0] exp_val,
                                          input logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field_name, exp_val,
                     got_val);
            error_count++;
        end
    endfunction

    task automatic issue_request(input ffba_pkg::req_t r);
        while (!no_idle && $urandom_range(99) < 10)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_responses.push_back(predict_response(r));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic alloc_bytes(input int unsigned n);
        ffba_pkg::req_t r;
        r.mode          = ffba_pkg::MODE_ALLOC;
        r.request_bytes = 16'(n);
        r.handle        = 6'($urandom);
        issue_request(r);
    endtask

    task automatic free_handle(input int unsigned h);
        ffba_pkg::req_t r;
        r.mode          = ffba_pkg::MODE_FREE;
        r.request_bytes = 16'($urandom);
        r.handle        = 6'(h);
        issue_request(r);
    endtask

    task automatic settle_pool();
        req_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic test_size_checks();
        alloc_bytes(0);
        alloc_bytes(65535);
        alloc_bytes(POOL_BYTES + 1);
        alloc_bytes(POOL_BYTES);
        alloc_bytes(1);
        free_handle(5);
        free_handle(0);
        free_handle(0);
        free_handle(BLOCK_COUNT - 1);
        settle_pool();
    endtask

    task automatic test_fragmentation();
        alloc_bytes(1);
        alloc_bytes((BLOCK_COUNT - 2) * BLOCK_BYTES);
        alloc_bytes(BLOCK_BYTES);
        alloc_bytes(1);
        free_handle(0);
        free_handle(2);
        alloc_bytes(BLOCK_BYTES + 1);
        alloc_bytes(BLOCK_BYTES);
        free_handle(0);
        free_handle(1);
        free_handle(3);
        free_handle(2);
        settle_pool();
    endtask

    task automatic test_response_backpressure();
        int live;
        hold_requested = 1'b1;
        for (int n = 0; n < 24; n++)
        begin
            live = pick_live_handle();
            if (n % 3 == 2 && live >= 0)
                free_handle(live);
            else
                alloc_bytes($urandom_range(1, 96));
        end
        settle_pool();
    endtask

    task automatic test_random_traffic();
        int             roll;
        int             live;
        ffba_pkg::req_t r;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n < QUIET_ITEMS);
            roll = $urandom_range(99);
            live = pick_live_handle();
            if (roll < 8)
            begin
                r.mode          = 1'($urandom);
                r.request_bytes = 16'($urandom);
                r.handle        = 6'($urandom);
                issue_request(r);
            end
            else if (live >= 0 && (roll < 50 || pool_used_blocks > 48))
                free_handle(live);
            else if (roll < 90)
                alloc_bytes($urandom_range(1, 160));
            else if (roll < 96)
                alloc_bytes($urandom_range(1, POOL_BYTES));
            else
                alloc_bytes($urandom_range(0, 65535));
        end
        no_idle = 1'b0;
        settle_pool();
    endtask

    always @(negedge clk)
    begin
        if (hold_requested && hold_left == 0)
        begin
            hold_requested = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= !no_idle && ($urandom_range(99) < 10);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: response beat with no request outstanding, %s %0d",
                         $time, "expected none, got status", rsp.status);
                error_count++;
            end
            else
            begin
                head_rsp = pending_responses.pop_front();
                compare_field("status", 32'(head_rsp.status), 32'(rsp.status));
                compare_field("granted_handle", 32'(head_rsp.granted_handle),
                              32'(rsp.granted_handle));
                compare_field("first_block", 32'(head_rsp.first_block),
                              32'(rsp.first_block));
                compare_field("byte_offset", 32'(head_rsp.byte_offset),
                              32'(rsp.byte_offset));
                compare_field("granted_bytes", 32'(head_rsp.granted_bytes),
                              32'(rsp.granted_bytes));
                compare_field("blocks_in_use", 32'(head_rsp.blocks_in_use),
                              32'(rsp.blocks_in_use));
                compare_field("peak_blocks", 32'(head_rsp.peak_blocks),
                              32'(rsp.peak_blocks));
                compare_field("request_total", head_rsp.request_total, rsp.request_total);
                status_seen[head_rsp.status]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_size_checks();
        test_fragmentation();
        test_response_backpressure();
        test_random_traffic();
        $display("Covered %0d requests: ok %0d, zero size %0d, over total %0d, over free %0d,",
                 items_sent, status_seen[ffba_pkg::ST_OK], status_seen[ffba_pkg::ST_ZERO_SIZE],
                 status_seen[ffba_pkg::ST_OVER_TOTAL], status_seen[ffba_pkg::ST_OVER_FREE]);
        $display("no handle %0d, no run %0d, bad handle %0d, peak blocks in use %0d.",
                 status_seen[ffba_pkg::ST_NO_HANDLE], status_seen[ffba_pkg::ST_NO_RUN],
                 status_seen[ffba_pkg::ST_BAD_HANDLE], pool_peak_blocks);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
src/ffba_pkg.sv
src/first_fit_block_allocator.sv
src/ffba_checker.sv
test/first_fit_block_allocator_tb.sv
